// ----- src/kst_pkg.sv -----
package kst_pkg;

  // Table geometry; SLOTS is a power of two so the slot index is a bit slice
  localparam int unsigned SLOTS   = 1024;
  localparam int unsigned SLOT_W  = $clog2(SLOTS);
  localparam int unsigned CNT_W   = SLOT_W + 1;
  localparam int unsigned SEQ_MAX = 65535;

  // Field widths of the request and response beats
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned LIMIT_W  = 11;
  localparam int unsigned IDENT_W  = 31;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned RSLOT_W  = 10;
  localparam int unsigned SEQ_W    = 16;
  localparam int unsigned LIVE_W   = 11;

  // Request kinds
  localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  // Response status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // One table entry: valid mark over the key
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } entry_t;

endpackage

// ----- src/kst_req_if.sv -----
interface kst_req_if;
  logic                          valid;
  logic                          ready;
  logic [kst_pkg::FUNC_W-1:0]    func;
  logic signed [kst_pkg::KEY_W-1:0] key;
  logic [kst_pkg::LIMIT_W-1:0]   search_limit;
  logic [kst_pkg::IDENT_W-1:0]   ident;

  modport source (output valid, func, key, search_limit, ident, input ready);
  modport sink (input valid, func, key, search_limit, ident, output ready);
endinterface

// ----- src/kst_rsp_if.sv -----
interface kst_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [kst_pkg::STATUS_W-1:0]     status;
  logic [kst_pkg::RSLOT_W-1:0]      slot;
  logic [kst_pkg::SEQ_W-1:0]        seq_number;
  logic signed [kst_pkg::KEY_W-1:0] removed_key;
  logic [kst_pkg::LIVE_W-1:0]       live_entries;

  modport source (output valid, status, slot, seq_number, removed_key, live_entries,
                  input ready);
  modport sink (input valid, status, slot, seq_number, removed_key, live_entries,
                output ready);
endinterface

// ----- src/kst_mem.sv -----
module kst_mem (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [kst_pkg::SLOT_W-1:0]  waddr_i,
  input  kst_pkg::entry_t             wdata_i,
  input  logic [kst_pkg::SLOT_W-1:0]  raddr_i,
  output kst_pkg::entry_t             rdata_o
);

  kst_pkg::entry_t mem_q [kst_pkg::SLOTS];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/keyed_slot_table.sv -----
// Keyed slot table: SLOTS slots, each holding a valid mark and a 32-bit key.
// Request channel (req_i): func selects find, add or remove; key, search_limit
// and ident ride along. Response channel (rsp_o): exactly one beat per request
// with status, slot, seq_number, removed_key and live_entries.
// One request is in work at a time; the next is taken once the previous one
// has moved into the output register.
// Find scans upward from slot 0 and stops at the matching slot or after the
// highest used slot (no scan on an empty table); add stops at the first free
// slot or after min(limit, SLOTS) slots (no scan for limit zero). Remove
// reads its slot and, when the highest used slot is freed, the table walks
// down to the new top.
// Each scan step is one read of the entry memory, so its single read port
// sets the pace: one slot per cycle.
// After reset the block sweeps every slot of the entry memory to empty, one
// slot per cycle, with req_i.ready low.
// A stalled receiver holds the response in the output register; the block
// still finishes the next request but holds it until the register frees.
module keyed_slot_table (
  input  logic      clk_i,
  input  logic      rst_ni,
  kst_req_if.sink   req_i,
  kst_rsp_if.source rsp_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_REM,
    S_WALK,
    S_DONE
  } state_e;

  state_e                         state_q;
  logic [kst_pkg::SLOT_W-1:0]     clr_q;
  logic [kst_pkg::FUNC_W-1:0]     func_q;
  logic [kst_pkg::KEY_W-1:0]      key_q;
  logic [kst_pkg::SLOT_W-1:0]     lid_q;
  logic [kst_pkg::CNT_W-1:0]      end_q;
  logic [kst_pkg::CNT_W-1:0]      cnt_q;
  logic                           pend_q;
  logic [kst_pkg::SLOT_W-1:0]     paddr_q;
  logic [kst_pkg::CNT_W-1:0]      top_q;   // highest used slot plus one
  logic [kst_pkg::CNT_W-1:0]      live_q;
  logic [kst_pkg::SEQ_W-1:0]      seq_q;

  logic [kst_pkg::STATUS_W-1:0]   res_status_q;
  logic [kst_pkg::RSLOT_W-1:0]    res_slot_q;
  logic [kst_pkg::SEQ_W-1:0]      res_seq_q;
  logic [kst_pkg::KEY_W-1:0]      res_rkey_q;

  logic                           out_valid_q;
  logic [kst_pkg::STATUS_W-1:0]   out_status_q;
  logic [kst_pkg::RSLOT_W-1:0]    out_slot_q;
  logic [kst_pkg::SEQ_W-1:0]      out_seq_q;
  logic [kst_pkg::KEY_W-1:0]      out_rkey_q;
  logic [kst_pkg::LIVE_W-1:0]     out_live_q;

  logic                           mem_we;
  logic [kst_pkg::SLOT_W-1:0]     mem_waddr;
  kst_pkg::entry_t                mem_wdata;
  logic [kst_pkg::SLOT_W-1:0]     mem_raddr;
  kst_pkg::entry_t                mem_rdata;

  logic [kst_pkg::CNT_W-1:0]      limit_cap;
  logic [kst_pkg::CNT_W-1:0]      cnt_dec;
  logic [kst_pkg::CNT_W-1:0]      paddr_inc;
  logic                           issue_up;
  logic                           issue_dn;
  logic                           scan_hit;
  logic                           out_free;

  kst_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Scan bookkeeping
  assign limit_cap = (req_i.search_limit > kst_pkg::LIMIT_W'(kst_pkg::SLOTS))
                   ? kst_pkg::CNT_W'(kst_pkg::SLOTS)
                   : kst_pkg::CNT_W'(req_i.search_limit);
  assign cnt_dec   = cnt_q - kst_pkg::CNT_W'(1);
  assign paddr_inc = kst_pkg::CNT_W'(paddr_q) + kst_pkg::CNT_W'(1);
  assign issue_up  = (state_q == S_SCAN) && (cnt_q < end_q);
  assign issue_dn  = (state_q == S_WALK) && (cnt_q != '0);
  assign scan_hit  = pend_q && ((func_q == kst_pkg::FUNC_ADD) ? !mem_rdata.valid
                   : (mem_rdata.valid && (mem_rdata.key == key_q)));
  assign out_free  = !out_valid_q || rsp_o.ready;

  // Memory read address: the request's slot while idle, else the scan pointer
  always_comb begin
    unique case (state_q)
      S_IDLE:  mem_raddr = req_i.ident[kst_pkg::SLOT_W-1:0];
      S_WALK:  mem_raddr = cnt_dec[kst_pkg::SLOT_W-1:0];
      default: mem_raddr = cnt_q[kst_pkg::SLOT_W-1:0];
    endcase
  end

  // Memory writes: clearing sweep, add allocation, remove release.
  // A read that meets a write to the same slot is never used, since the
  // sequencer only reads a slot for use after the write to it has landed.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = '0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_SCAN: begin
        if (scan_hit && (func_q == kst_pkg::FUNC_ADD)) begin
          mem_we    = 1'b1;
          mem_waddr = paddr_q;
          mem_wdata = '{valid: 1'b1, key: key_q};
        end
      end
      S_REM: begin
        if (mem_rdata.valid) begin
          mem_we    = 1'b1;
          mem_waddr = lid_q;
          mem_wdata = '{valid: 1'b0, key: mem_rdata.key};
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      func_q       <= '0;
      key_q        <= '0;
      lid_q        <= '0;
      end_q        <= '0;
      cnt_q        <= '0;
      pend_q       <= 1'b0;
      paddr_q      <= '0;
      top_q        <= '0;
      live_q       <= '0;
      seq_q        <= '0;
      res_status_q <= '0;
      res_slot_q   <= '0;
      res_seq_q    <= '0;
      res_rkey_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_slot_q   <= '0;
      out_seq_q    <= '0;
      out_rkey_q   <= '0;
      out_live_q   <= '0;
    end else begin
      // S_DONE refills the register itself when it frees
      if (out_valid_q && rsp_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + kst_pkg::SLOT_W'(1);
          if (clr_q == kst_pkg::SLOT_W'(kst_pkg::SLOTS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_i.valid) begin
            func_q       <= req_i.func;
            key_q        <= req_i.key;
            lid_q        <= req_i.ident[kst_pkg::SLOT_W-1:0];
            cnt_q        <= '0;
            pend_q       <= 1'b0;
            res_status_q <= kst_pkg::STATUS_MISS;
            res_slot_q   <= '0;
            res_seq_q    <= '0;
            res_rkey_q   <= '0;
            case (req_i.func)
              kst_pkg::FUNC_FIND: begin
                end_q   <= top_q;
                state_q <= (top_q == '0) ? S_DONE : S_SCAN;
              end
              kst_pkg::FUNC_ADD: begin
                end_q   <= limit_cap;
                state_q <= (limit_cap == '0) ? S_DONE : S_SCAN;
              end
              kst_pkg::FUNC_REMOVE: begin
                state_q <= S_REM;
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          // one read issued per cycle, its data checked in the next cycle
          pend_q  <= issue_up;
          paddr_q <= cnt_q[kst_pkg::SLOT_W-1:0];
          if (issue_up) begin
            cnt_q <= cnt_q + kst_pkg::CNT_W'(1);
          end
          if (scan_hit) begin
            res_status_q <= kst_pkg::STATUS_OK;
            res_slot_q   <= kst_pkg::RSLOT_W'(paddr_q);
            if (func_q == kst_pkg::FUNC_ADD) begin
              live_q    <= live_q + kst_pkg::CNT_W'(1);
              res_seq_q <= seq_q;
              seq_q     <= (seq_q == kst_pkg::SEQ_W'(kst_pkg::SEQ_MAX))
                         ? '0 : seq_q + kst_pkg::SEQ_W'(1);
              if (paddr_inc > top_q) begin
                top_q <= paddr_inc;
              end
            end
            state_q <= S_DONE;
          end else if (!pend_q && !issue_up) begin
            state_q <= S_DONE;
          end
        end
        S_REM: begin
          if (!mem_rdata.valid) begin
            res_status_q <= kst_pkg::STATUS_EMPTY;
            state_q      <= S_DONE;
          end else begin
            res_status_q <= kst_pkg::STATUS_OK;
            res_slot_q   <= kst_pkg::RSLOT_W'(lid_q);
            res_rkey_q   <= mem_rdata.key;
            if (live_q != '0) begin
              live_q <= live_q - kst_pkg::CNT_W'(1);
            end
            // freeing the top slot: walk down to the next used one
            if (kst_pkg::CNT_W'(lid_q) + kst_pkg::CNT_W'(1) == top_q) begin
              cnt_q   <= kst_pkg::CNT_W'(lid_q);
              pend_q  <= 1'b0;
              state_q <= S_WALK;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_WALK: begin
          pend_q  <= issue_dn;
          paddr_q <= cnt_dec[kst_pkg::SLOT_W-1:0];
          if (issue_dn) begin
            cnt_q <= cnt_dec;
          end
          if (pend_q && mem_rdata.valid) begin
            top_q   <= paddr_inc;
            state_q <= S_DONE;
          end else if (!pend_q && !issue_dn) begin
            top_q   <= '0;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_slot_q   <= res_slot_q;
            out_seq_q    <= res_seq_q;
            out_rkey_q   <= res_rkey_q;
            out_live_q   <= kst_pkg::LIVE_W'(live_q);
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Channel outputs
  assign req_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.slot         = out_slot_q;
  assign rsp_o.seq_number   = out_seq_q;
  assign rsp_o.removed_key  = out_rkey_q;
  assign rsp_o.live_entries = out_live_q;

  // Occupancy never exceeds the span up to the highest used slot
  a_live_le_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= top_q)
    else $error("live count above highest used slot");

  // Outside the walk-down, an empty span means an empty table and the other way round
  a_top_live_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_WALK) |-> ((top_q == '0) == (live_q == '0)))
    else $error("highest used slot and live count disagree");

  // A response appears only as the sequencer finishes a request
  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("response raised outside completion");

  // No memory write while a new request is being taken
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we)
    else $error("memory write while idle");

endmodule
